FILE: src/ces_pkg.sv
// ----------------------------------------------------------------------------
// Cubic elastic stress package
// Shared widths, payload types, register indexes, pipeline control and the
// 48-bit output saturation used by the stress and energy datapaths.
// ----------------------------------------------------------------------------
package ces_pkg;

   localparam int GRAD_W = 24;   // Q2.22 gradient terms
   localparam int COEF_W = 32;   // Q16.16 constants
   localparam int OUT_W  = 48;   // Q32.16 results

   localparam logic signed [63:0] SAT_HI = 64'sd140737488355327;
   localparam logic signed [63:0] SAT_LO = -64'sd140737488355328;

   typedef enum logic [1:0] {
      CSR_C11   = 2'd0,
      CSR_C12   = 2'd1,
      CSR_C44   = 2'd2,
      CSR_GAMMA = 2'd3
   } ces_csr_idx_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_xx;
      logic signed [GRAD_W-1:0] grad_yy;
      logic signed [GRAD_W-1:0] grad_zz;
      logic signed [GRAD_W-1:0] shear_xy;
      logic signed [GRAD_W-1:0] shear_xz;
      logic signed [GRAD_W-1:0] shear_yz;
      logic signed [GRAD_W-1:0] rate_xx;
      logic signed [GRAD_W-1:0] rate_yy;
      logic signed [GRAD_W-1:0] rate_zz;
      logic signed [GRAD_W-1:0] rate_shear_xy;
      logic signed [GRAD_W-1:0] rate_shear_xz;
      logic signed [GRAD_W-1:0] rate_shear_yz;
   } ces_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] stress_xx;
      logic signed [OUT_W-1:0] stress_yy;
      logic signed [OUT_W-1:0] stress_zz;
      logic signed [OUT_W-1:0] stress_xy;
      logic signed [OUT_W-1:0] stress_xz;
      logic signed [OUT_W-1:0] stress_yz;
      logic signed [OUT_W-1:0] energy_density;
   } ces_rsp_type;

   // Per-stage load enables of the four-stage pipeline.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } ces_ctl_type;

   // Clamp a wide signed value to the signed 48-bit output range.
   function automatic logic signed [OUT_W-1:0] sat48(input logic signed [63:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/cubic_elastic_stress_damped.sv
// ----------------------------------------------------------------------------
// Cubic elastic stress with viscous damping
// Streams integration points and returns the negated cubic-elastic stress
// with damping, plus the elastic energy density, one result per point.
// ----------------------------------------------------------------------------
//
// Usage:
//   The request channel carries one integration point per transfer: three
//   normal displacement gradients, three shear sums and the same six terms
//   of the velocity gradient, all signed Q2.22. The response channel returns
//   six stress components and the energy density, signed Q32.16, saturated
//   to 48 bits. A transfer happens on a rising edge where valid is high and
//   stall is low.
//   The constants c11, c12, c44 and the damping coefficient are written
//   through the csr port, which is always ready. Write them only while no
//   point is in flight.
//   A response is valid once its point has passed the four stage registers.
//   The pipeline (products, sums and scaling, constant products and
//   saturation, energy sum) takes one point every cycle when not stalled.
//   When the receiver stalls, the pipeline keeps filling its empty stages
//   and stalls the sender only once the held stages back up to the input.
//   Reset clears all stage valid bits and sets every constant to zero.
//
module cubic_elastic_stress_damped import ces_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ces_req_type             req_data,
   // Response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ces_rsp_type             rsp_data,
   // Configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [COEF_W-1:0]       csr_data
);

   // Configuration registers.
   logic signed [COEF_W-1:0] c11_ff, c12_ff, c44_ff, gamma_ff;

   // Pipeline valid bits and load enables.
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   ces_ctl_type ctl;

   // Stage 1: constant-by-gradient products.
   logic signed [GRAD_W-1:0] nu [3];
   logic signed [GRAD_W:0]   pair [3];
   logic signed [GRAD_W-1:0] nv [3];
   logic signed [GRAD_W-1:0] ss [3];
   logic signed [GRAD_W-1:0] sr [3];

   logic signed [55:0] p11_in [3], p11_ff [3];
   logic signed [56:0] p12_in [3], p12_ff [3];
   logic signed [55:0] pgn_in [3], pgn_ff [3];
   logic signed [55:0] p44_in [3], p44_ff [3];
   logic signed [55:0] pgs_in [3], pgs_ff [3];

   // Stage 2: summed, negated and scaled stress.
   logic signed [59:0] nacc [3];
   logic signed [59:0] nsh [3];
   logic signed [59:0] sacc [3];
   logic signed [59:0] ssh [3];
   logic signed [37:0] st2_in [6], st2_ff [6];

   // Stage 3 and 4: saturated stress, then aligned with the energy result.
   logic signed [OUT_W-1:0] st3_in [6], st3_ff [6];
   logic signed [OUT_W-1:0] st4_ff [6];

   logic signed [OUT_W-1:0] energy;

   // ------------------------------------------------------------------------
   // Configuration port. Writes are always accepted; csr_ready is tied high.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c11_ff   <= '0;
         c12_ff   <= '0;
         c44_ff   <= '0;
         gamma_ff <= '0;
      end else if (csr_valid) begin
         unique case (ces_csr_idx_type'(csr_index))
            CSR_C11:   c11_ff   <= csr_data;
            CSR_C12:   c12_ff   <= csr_data;
            CSR_C44:   c44_ff   <= csr_data;
            CSR_GAMMA: gamma_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. A stage loads when it is empty or when the stage after it
   // loads, so bubbles are squeezed out while the receiver stalls and no item
   // is lost or repeated.
   // ------------------------------------------------------------------------
   always_comb begin
      ctl.ld4 = !v4_ff || !rsp_stall;
      ctl.ld3 = !v3_ff || ctl.ld4;
      ctl.ld2 = !v2_ff || ctl.ld3;
      ctl.ld1 = !v1_ff || ctl.ld2;
   end

   assign req_stall = !ctl.ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ctl.ld1) begin
            v1_ff <= req_valid;
         end
         if (ctl.ld2) begin
            v2_ff <= v1_ff;
         end
         if (ctl.ld3) begin
            v3_ff <= v2_ff;
         end
         if (ctl.ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1. Each normal component needs c11 times its own gradient, c12
   // times the sum of the other two and gamma times its rate. Each shear
   // component needs c44 and gamma times its shear sums.
   // ------------------------------------------------------------------------
   always_comb begin
      nu[0] = req_data.grad_xx;
      nu[1] = req_data.grad_yy;
      nu[2] = req_data.grad_zz;
      pair[0] = 25'(req_data.grad_yy) + 25'(req_data.grad_zz);
      pair[1] = 25'(req_data.grad_xx) + 25'(req_data.grad_zz);
      pair[2] = 25'(req_data.grad_xx) + 25'(req_data.grad_yy);
      nv[0] = req_data.rate_xx;
      nv[1] = req_data.rate_yy;
      nv[2] = req_data.rate_zz;
      ss[0] = req_data.shear_xy;
      ss[1] = req_data.shear_xz;
      ss[2] = req_data.shear_yz;
      sr[0] = req_data.rate_shear_xy;
      sr[1] = req_data.rate_shear_xz;
      sr[2] = req_data.rate_shear_yz;
      for (int i = 0; i < 3; i++) begin
         p11_in[i] = 56'(c11_ff) * 56'(nu[i]);
         p12_in[i] = 57'(c12_ff) * 57'(pair[i]);
         pgn_in[i] = 56'(gamma_ff) * 56'(nv[i]);
         p44_in[i] = 56'(c44_ff) * 56'(ss[i]);
         pgs_in[i] = 56'(gamma_ff) * 56'(sr[i]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2. The sums are exact; negation comes before the arithmetic shift
   // so the result rounds toward minus infinity. The shear path doubles the
   // c44 term and shifts one bit further, which halves the damping exactly.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nacc[i] = -(60'(p11_ff[i]) + 60'(p12_ff[i]) + 60'(pgn_ff[i]));
         nsh[i]  = nacc[i] >>> 22;
         st2_in[i] = nsh[i][37:0];
         sacc[i] = -((60'(p44_ff[i]) <<< 1) + 60'(pgs_ff[i]));
         ssh[i]  = sacc[i] >>> 23;
         st2_in[i+3] = ssh[i][37:0];
      end
   end

   // Stage 3: saturation to the output range.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         st3_in[i] = sat48(64'(st2_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         p11_ff <= p11_in;
         p12_ff <= p12_in;
         pgn_ff <= pgn_in;
         p44_ff <= p44_in;
         pgs_ff <= pgs_in;
      end
      if (ctl.ld2) begin
         st2_ff <= st2_in;
      end
      if (ctl.ld3) begin
         st3_ff <= st3_in;
      end
      if (ctl.ld4) begin
         st4_ff <= st3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Energy density runs in its own pipeline under the same load enables.
   // ------------------------------------------------------------------------
   ces_energy u_energy (
      .clock  (clock),
      .ctl    (ctl),
      .req    (req_data),
      .c11    (c11_ff),
      .c12    (c12_ff),
      .c44    (c44_ff),
      .energy (energy)
   );

   // ------------------------------------------------------------------------
   // Response channel, driven straight from the last stage.
   // ------------------------------------------------------------------------
   assign rsp_valid = v4_ff;

   always_comb begin
      rsp_data.stress_xx      = st4_ff[0];
      rsp_data.stress_yy      = st4_ff[1];
      rsp_data.stress_zz      = st4_ff[2];
      rsp_data.stress_xy      = st4_ff[3];
      rsp_data.stress_xz      = st4_ff[4];
      rsp_data.stress_yz      = st4_ff[5];
      rsp_data.energy_density = energy;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // With every stage full and the receiver stalling, the sender must stall.
   a_full_stalls_input : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall) |-> req_stall)
      else $error("pipeline full under stall but input not stalled");

   // An accepted request occupies the first stage on the next cycle.
   a_accept_fills_stage1 : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request did not enter stage 1");

   // A stage held behind a stalled output keeps its item.
   a_stage3_holds : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && rsp_stall) |=> v3_ff)
      else $error("stage 3 item lost while output stalled");

   // The output stage never empties while the receiver stalls it.
   a_stage4_holds : assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp_stall) |=> (v4_ff && $stable(st4_ff[0]) && $stable(energy)))
      else $error("output stage changed while stalled");

endmodule

FILE: src/ces_energy.sv
// ----------------------------------------------------------------------------
// Elastic energy pipeline
// Four register stages: truncated gradient products, partial sums, constant
// products, then the final sum, scaling and saturation.
// ----------------------------------------------------------------------------
module ces_energy import ces_pkg::*; (
   input  logic                     clock,
   input  ces_ctl_type              ctl,
   input  ces_req_type              req,
   input  logic signed [COEF_W-1:0] c11,
   input  logic signed [COEF_W-1:0] c12,
   input  logic signed [COEF_W-1:0] c44,
   output logic signed [OUT_W-1:0]  energy
);

   logic signed [GRAD_W-1:0]   op_a [9];
   logic signed [GRAD_W-1:0]   op_b [9];
   logic signed [2*GRAD_W-1:0] prod [9];
   logic signed [2*GRAD_W-1:0] prod_sh [9];
   logic signed [25:0]         q_in [9];
   logic signed [25:0]         q_ff [9];

   logic signed [27:0] ssh_in, scr_in, snm_in;
   logic signed [27:0] ssh_ff, scr_ff, snm_ff;

   logic signed [59:0] m44_in, m12_in, m11_in;
   logic signed [59:0] m44_ff, m12_ff, m11_ff;

   logic signed [63:0]       e_sum;
   logic signed [63:0]       e_sh;
   logic signed [OUT_W-1:0]  energy_in;
   logic signed [OUT_W-1:0]  energy_ff;

   // Shear squares, cross products, normal squares.
   always_comb begin
      op_a[0] = req.shear_xy; op_b[0] = req.shear_xy;
      op_a[1] = req.shear_xz; op_b[1] = req.shear_xz;
      op_a[2] = req.shear_yz; op_b[2] = req.shear_yz;
      op_a[3] = req.grad_xx;  op_b[3] = req.grad_yy;
      op_a[4] = req.grad_xx;  op_b[4] = req.grad_zz;
      op_a[5] = req.grad_yy;  op_b[5] = req.grad_zz;
      op_a[6] = req.grad_xx;  op_b[6] = req.grad_xx;
      op_a[7] = req.grad_yy;  op_b[7] = req.grad_yy;
      op_a[8] = req.grad_zz;  op_b[8] = req.grad_zz;
      for (int i = 0; i < 9; i++) begin
         prod[i]    = op_a[i] * op_b[i];
         prod_sh[i] = prod[i] >>> 22;
         q_in[i]    = prod_sh[i][25:0];
      end
   end

   always_comb begin
      ssh_in = 28'(q_ff[0]) + 28'(q_ff[1]) + 28'(q_ff[2]);
      scr_in = 28'(q_ff[3]) + 28'(q_ff[4]) + 28'(q_ff[5]);
      snm_in = 28'(q_ff[6]) + 28'(q_ff[7]) + 28'(q_ff[8]);
   end

   always_comb begin
      m44_in = 60'(c44) * 60'(ssh_ff);
      m12_in = 60'(c12) * 60'(scr_ff);
      m11_in = 60'(c11) * 60'(snm_ff);
   end

   // The cross term carries twice c12.
   always_comb begin
      e_sum     = 64'(m44_ff) + (64'(m12_ff) <<< 1) + 64'(m11_ff);
      e_sh      = e_sum >>> 23;
      energy_in = sat48(e_sh);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         q_ff <= q_in;
      end
      if (ctl.ld2) begin
         ssh_ff <= ssh_in;
         scr_ff <= scr_in;
         snm_ff <= snm_in;
      end
      if (ctl.ld3) begin
         m44_ff <= m44_in;
         m12_ff <= m12_in;
         m11_ff <= m11_in;
      end
      if (ctl.ld4) begin
         energy_ff <= energy_in;
      end
   end

   assign energy = energy_ff;

endmodule

FILE: tb/sv/cubic_elastic_stress_damped_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic elastic stress testbench
// Streams integration points through the stress pipeline and compares every
// response with a bit-exact model of the damped cubic Hooke law. The run
// starts with a short directed table and then sweeps several sets of
// constants with random points. Random idle and stall cycles are applied on
// both channels, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module cubic_elastic_stress_damped_tb import ces_pkg::*; ();

   localparam int PHASES       = 8;     // random phases, each with new constants
   localparam int PHASE_POINTS = 144;   // random points per phase
   localparam int HOLD_CYCLES  = 400;   // the long receiver hold-off
   localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer
   localparam int PIPE_DEPTH   = 4;

   localparam logic signed [GRAD_W-1:0] ONE_Q22  = 24'sh400000;
   localparam logic signed [GRAD_W-1:0] GRAD_MAX = 24'sh7fffff;
   localparam logic signed [GRAD_W-1:0] GRAD_MIN = 24'sh800000;
   localparam logic signed [COEF_W-1:0] ONE_Q16  = 32'sh00010000;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fffffff;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;

   localparam longint RSP_MAX = 64'sd140737488355327;
   localparam longint RSP_MIN = -64'sd140737488355328;

   // The four constants in register order: c11, c12, c44, gamma.
   typedef logic signed [COEF_W-1:0] coef_set_type [4];

   // One row of the directed stimulus. Where known is set, rsp holds the
   // response typed in by hand; otherwise the response is predicted.
   typedef struct {
      int           cfg;
      ces_req_type  point;
      bit           known;
      ces_rsp_type  rsp;
   } point_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ces_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ces_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_C11;
   logic [COEF_W-1:0] csr_data = '0;

   // Shadow copies of the constants, updated on each accepted register write.
   longint      k_c11 = 0;
   longint      k_c12 = 0;
   longint      k_c44 = 0;
   longint      k_gamma = 0;

   ces_rsp_type   stress_expect_q[$];
   point_row_type point_rows[$];
   coef_set_type  cfg_sets [5];
   int          errors = 0;
   int          quiet_cycles = 0;
   int unsigned tx_burst = 0;
   int unsigned rx_burst = 0;
   bit          hold_pending = 1'b0;

   cubic_elastic_stress_damped u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic logic signed [OUT_W-1:0] clamp_q16(input longint v);
      if (v > RSP_MAX) begin
         return RSP_MAX[OUT_W-1:0];
      end else if (v < RSP_MIN) begin
         return RSP_MIN[OUT_W-1:0];
      end
      return v[OUT_W-1:0];
   endfunction

   // Product of two Q2.22 terms, truncated toward minus infinity to 22
   // fractional bits while keeping all integer bits.
   function automatic longint trunc_q22(input longint a, input longint b);
      return (a * b) >>> 22;
   endfunction

   // Every sum of constant-by-gradient products is exact in 64 bits; the
   // arithmetic shift then floors it. Shear rows shift by one more bit so
   // that the halved damping term stays exact: the elastic part carries an
   // extra factor of two instead.
   function automatic ces_rsp_type predict_stress(input ces_req_type p);
      longint uxx, uyy, uzz, sxy, sxz, syz;
      longint vxx, vyy, vzz, rxy, rxz, ryz;
      longint shear_sq, cross_sq, normal_sq;
      ces_rsp_type s;
      uxx = longint'(p.grad_xx);  uyy = longint'(p.grad_yy);  uzz = longint'(p.grad_zz);
      sxy = longint'(p.shear_xy); sxz = longint'(p.shear_xz); syz = longint'(p.shear_yz);
      vxx = longint'(p.rate_xx);  vyy = longint'(p.rate_yy);  vzz = longint'(p.rate_zz);
      rxy = longint'(p.rate_shear_xy);
      rxz = longint'(p.rate_shear_xz);
      ryz = longint'(p.rate_shear_yz);

      s.stress_xx = clamp_q16(-(k_c11 * uxx + k_c12 * (uyy + uzz) + k_gamma * vxx) >>> 22);
      s.stress_yy = clamp_q16(-(k_c11 * uyy + k_c12 * (uxx + uzz) + k_gamma * vyy) >>> 22);
      s.stress_zz = clamp_q16(-(k_c11 * uzz + k_c12 * (uxx + uyy) + k_gamma * vzz) >>> 22);
      s.stress_xy = clamp_q16(-(2 * k_c44 * sxy + k_gamma * rxy) >>> 23);
      s.stress_xz = clamp_q16(-(2 * k_c44 * sxz + k_gamma * rxz) >>> 23);
      s.stress_yz = clamp_q16(-(2 * k_c44 * syz + k_gamma * ryz) >>> 23);

      // The energy uses the shear sums directly, so the quarter from
      // u_ij = sum/2 folds into the final shift together with the half.
      shear_sq  = trunc_q22(sxy, sxy) + trunc_q22(sxz, sxz) + trunc_q22(syz, syz);
      cross_sq  = trunc_q22(uxx, uyy) + trunc_q22(uxx, uzz) + trunc_q22(uyy, uzz);
      normal_sq = trunc_q22(uxx, uxx) + trunc_q22(uyy, uyy) + trunc_q22(uzz, uzz);
      s.energy_density = clamp_q16((k_c44 * shear_sq + 2 * k_c12 * cross_sq
                                    + k_c11 * normal_sq) >>> 23);
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic ces_rsp_type typed_rsp(input longint xx, input longint yy,
                                             input longint zz, input longint xy,
                                             input longint xz, input longint yz,
                                             input longint en);
      ces_rsp_type r;
      r.stress_xx = xx[OUT_W-1:0];
      r.stress_yy = yy[OUT_W-1:0];
      r.stress_zz = zz[OUT_W-1:0];
      r.stress_xy = xy[OUT_W-1:0];
      r.stress_xz = xz[OUT_W-1:0];
      r.stress_yz = yz[OUT_W-1:0];
      r.energy_density = en[OUT_W-1:0];
      return r;
   endfunction

   task automatic add_row(input int cfg, input ces_req_type p, input bit known,
                          input ces_rsp_type rsp);
      point_row_type row;
      row.cfg = cfg;
      row.point = p;
      row.known = known;
      row.rsp = rsp;
      point_rows.push_back(row);
   endtask

   // Gradients lean toward the corners of the Q2.22 range, toward zero and toward
   // values within plus or minus one, with plenty of fully random words so every bit toggles.
   function automatic logic signed [GRAD_W-1:0] rand_grad();
      unique case ($urandom_range(0, 7))
         0, 1, 2: return GRAD_W'($urandom);
         3:       return GRAD_MAX;
         4:       return GRAD_MIN;
         5:       return '0;
         default: return GRAD_W'($urandom_range(0, 2 * ONE_Q22) - ONE_Q22);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] rand_coef();
      unique case ($urandom_range(0, 6))
         0, 1:    return $urandom;
         2:       return COEF_MAX;
         3:       return COEF_MIN;
         4:       return '0;
         default: return $urandom_range(0, 32'h00200000) - 32'sh00100000;
      endcase
   endfunction

   function automatic ces_req_type rand_point();
      ces_req_type p;
      for (int i = 0; i < 12; i++) begin
         p[i*GRAD_W +: GRAD_W] = rand_grad();
      end
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (errors < 200) begin
         $display("%0t ns: %s", $realtime, what);
      end
      errors++;
   endtask

   task automatic check_field(input string name, input logic signed [OUT_W-1:0] got,
                              input logic signed [OUT_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
      end
   endtask

   // Every response transfer is compared with the oldest expected response.
   always @(posedge clock) begin
      ces_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stress_expect_q.size() == 0) begin
            report_mismatch("response transfer with no point outstanding");
         end else begin
            want = stress_expect_q.pop_front();
            check_field("stress_xx", rsp_data.stress_xx, want.stress_xx);
            check_field("stress_yy", rsp_data.stress_yy, want.stress_yy);
            check_field("stress_zz", rsp_data.stress_zz, want.stress_zz);
            check_field("stress_xy", rsp_data.stress_xy, want.stress_xy);
            check_field("stress_xz", rsp_data.stress_xz, want.stress_xz);
            check_field("stress_yz", rsp_data.stress_yz, want.stress_yz);
            check_field("energy_density", rsp_data.energy_density, want.energy_density);
         end
      end
   end

   // The watchdog counts cycles without a transfer on any channel. Its limit
   // is well above the long hold-off plus the worst gap, stall and latency.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one point after a random idle gap and returns at the edge of its
   // transfer with valid still high, so a back-to-back point keeps valid up
   // without a low pulse. The expected response is queued at the transfer.
   task automatic send_point(input ces_req_type p, input bit known,
                             input ces_rsp_type rsp);
      int unsigned gap;
      if (tx_burst > 0) begin
         tx_burst--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) begin
            tx_burst = $urandom_range(20, 60);
         end
         gap = $urandom_range(0, 14);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stress_expect_q.push_back(known ? rsp : predict_stress(p));
   endtask

   // Stops offering points and waits until every outstanding response has
   // come back, so the constants can be rewritten with the pipeline empty.
   task automatic drain_points();
      req_valid <= 1'b0;
      while (stress_expect_q.size() != 0) @(posedge clock);
   endtask

   // Writes all four constants back to back, keeping the shadow copies in
   // step with each accepted write.
   task automatic apply_config(input coef_set_type set);
      ces_csr_idx_type order [4];
      order = '{CSR_C11, CSR_C12, CSR_C44, CSR_GAMMA};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= set[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         unique case (order[i])
            CSR_C11:   k_c11   = longint'(set[i]);
            CSR_C12:   k_c12   = longint'(set[i]);
            CSR_C44:   k_c44   = longint'(set[i]);
            CSR_GAMMA: k_gamma = longint'(set[i]);
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------

   // Constant sets: reset zeros, all 1.0, all at the positive extreme, all
   // at the negative extreme, and a mix with damping switched off.
   task automatic build_points();
      ces_req_type p;
      ces_rsp_type none;
      none = '0;
      cfg_sets[0] = '{32'sh0, 32'sh0, 32'sh0, 32'sh0};
      cfg_sets[1] = '{ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16};
      cfg_sets[2] = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
      cfg_sets[3] = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
      cfg_sets[4] = '{COEF_MAX, COEF_MIN, ONE_Q16, 32'sh0};

      // Right after reset every constant is zero, so every output is zero.
      add_row(0, {12{24'sh000000}}, 1'b1, none);
      add_row(0, {12{GRAD_MAX}}, 1'b1, none);
      add_row(0, {12{GRAD_MIN}}, 1'b1, none);

      // With every constant at 1.0, single unit terms give readable results:
      // a unit normal gradient loads all three normal rows and half a unit
      // of energy, and the damping shear sees only half the rate sum.
      p = '0; p.grad_xx = ONE_Q22;
      add_row(1, p, 1'b1, typed_rsp(-65536, -65536, -65536, 0, 0, 0, 32768));
      p = '0; p.shear_xy = ONE_Q22;
      add_row(1, p, 1'b1, typed_rsp(0, 0, 0, -65536, 0, 0, 32768));
      p = '0; p.rate_xx = ONE_Q22;
      add_row(1, p, 1'b1, typed_rsp(-65536, 0, 0, 0, 0, 0, 0));
      p = '0; p.rate_shear_xy = ONE_Q22;
      add_row(1, p, 1'b1, typed_rsp(0, 0, 0, -32768, 0, 0, 0));
      // One LSB of gradient: the negated result floors to -1, while minus
      // one LSB floors to zero, and the squared LSB vanishes in the energy.
      p = '0; p.grad_xx = 24'sd1;
      add_row(1, p, 1'b1, typed_rsp(-1, -1, -1, 0, 0, 0, 0));
      p = '0; p.grad_xx = -24'sd1;
      add_row(1, p, 1'b1, none);
      p = '0; p.rate_shear_yz = 24'sd1;
      add_row(1, p, 1'b0, none);
      p = '0; p.grad_xx = ONE_Q22; p.grad_yy = ONE_Q22; p.grad_zz = -ONE_Q22;
      add_row(1, p, 1'b0, none);
      p = '0; p.shear_xz = GRAD_MIN; p.shear_yz = GRAD_MAX; p.rate_shear_xz = GRAD_MAX;
      add_row(1, p, 1'b0, none);
      add_row(1, {12{GRAD_MAX}}, 1'b0, none);
      add_row(1, {12{GRAD_MIN}}, 1'b0, none);

      // The largest products and sums the datapath can see.
      add_row(2, {12{GRAD_MAX}}, 1'b0, none);
      add_row(2, {12{GRAD_MIN}}, 1'b0, none);
      add_row(2, {6{GRAD_MAX, GRAD_MIN}}, 1'b0, none);
      add_row(3, {12{GRAD_MAX}}, 1'b0, none);
      add_row(3, {12{GRAD_MIN}}, 1'b0, none);
      add_row(3, {6{GRAD_MIN, GRAD_MAX}}, 1'b0, none);
      add_row(4, {6{GRAD_MAX, GRAD_MIN}}, 1'b0, none);
      add_row(4, {12{GRAD_MIN}}, 1'b0, none);
      add_row(4, rand_point(), 1'b0, none);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Draws a stall length for every response. Once, on request, it holds off
   // for a long stretch so that the pipeline backs up and stalls the sender.
   initial begin
      int unsigned n;
      @(negedge reset);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            n = HOLD_CYCLES;
         end else if (rx_burst > 0) begin
            rx_burst--;
            n = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) begin
               rx_burst = $urandom_range(20, 60);
            end
            n = $urandom_range(0, 14);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      int cur_cfg;
      coef_set_type set;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_points();
      cur_cfg = 0;
      foreach (point_rows[i]) begin
         if (point_rows[i].cfg != cur_cfg) begin
            drain_points();
            apply_config(cfg_sets[point_rows[i].cfg]);
            cur_cfg = point_rows[i].cfg;
         end
         send_point(point_rows[i].point, point_rows[i].known, point_rows[i].rsp);
      end

      // Random phases, each under freshly drawn constants.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_points();
         foreach (set[j]) set[j] = rand_coef();
         apply_config(set);
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (ph == 3 && n == 30) begin
               // Keep offering points back to back through the hold-off.
               hold_pending = 1'b1;
               tx_burst = 100;
            end
            send_point(rand_point(), 1'b0, '0);
         end
      end

      drain_points();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (errors == 0 && stress_expect_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
